/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted
`define ELU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication: post must hold in the cycle after pre holds
`define ELU_ASSERT_NEXT(lbl, pre, post, msg) \
	`ELU_ASSERT(lbl, (pre) |=> (post), msg)

`endif

/* rtl/core/elu_pkg.sv */
`default_nettype none

package elu_pkg;

	// Fixed data format of the beats
	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS_DEF = 8;
	localparam int EXP_DEPTH_DEF = 64;

	// Alpha register, unsigned Q4.8
	localparam int ALPHA_W = 12;
	localparam logic [ALPHA_W-1:0] ALPHA_RST = 12'd256;

	// Function select codes
	localparam logic FN_FWD  = 1'b0;
	localparam logic FN_GRAD = 1'b1;

	// Exponential table entries in unsigned Q30
	localparam int EXP_W = 31;
	localparam logic [EXP_W-1:0] EXP_ONE = 31'h4000_0000;

	typedef struct packed {
		logic                         func;
		logic signed [DATA_WIDTH-1:0] operand;
		logic signed [DATA_WIDTH-1:0] upstream_grad;
		logic                         last_in;
	} req_beat_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] result;
		logic                         last_out;
	} rsp_beat_t;

	// exp(-step*idx) in Q30: step ratio from a Taylor sum up to the 24th power,
	// then repeated rounded multiplication. Evaluated at elaboration.
	function automatic logic [EXP_W-1:0] exp_entry(longint unsigned step, int idx);
		longint unsigned term;
		longint unsigned ratio;
		longint unsigned val;
		int n;
		int k;
		term = 64'(EXP_ONE);
		ratio = 64'(EXP_ONE);
		for (n = 1; n <= 24; n++) begin
			term = ((term * step) >> 30) / 64'(n);
			if (n[0]) begin
				ratio = ratio - term;
			end else begin
				ratio = ratio + term;
			end
		end
		val = 64'(EXP_ONE);
		for (k = 1; k <= idx; k++) begin
			val = (val * ratio + (64'(EXP_ONE) >> 1)) >> 30;
		end
		return val[EXP_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/elu_exp_rom.sv */
`default_nettype none

// Constant exp table, read at a segment's two end points
module elu_exp_rom #(
	parameter int EXP_TABLE_DEPTH = elu_pkg::EXP_DEPTH_DEF,
	parameter int IDX_W = $clog2(EXP_TABLE_DEPTH)
) (
	input  wire logic [IDX_W-1:0]           idx,
	output logic      [elu_pkg::EXP_W-1:0]  ent_lo,
	output logic      [elu_pkg::EXP_W-1:0]  ent_hi
);

	localparam longint unsigned STEP = (64'd8 << 30) / EXP_TABLE_DEPTH;

	logic [elu_pkg::EXP_W-1:0] lo_tab [EXP_TABLE_DEPTH];
	logic [elu_pkg::EXP_W-1:0] hi_tab [EXP_TABLE_DEPTH];

	// segment start and end values
	for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_ent
		assign lo_tab[g] = elu_pkg::exp_entry(STEP, g);
		assign hi_tab[g] = elu_pkg::exp_entry(STEP, g + 1);
	end

	assign ent_lo = lo_tab[idx];
	assign ent_hi = hi_tab[idx];

endmodule

`default_nettype wire

/* rtl/core/elu_fwd.sv */
`default_nettype none

// Forward ELU for non-positive x: table interpolation, alpha scaling, rounding.
// Five register stages; the rounded and saturated value leaves combinationally.
module elu_fwd #(
	parameter int FRAC_BITS = elu_pkg::FRAC_BITS_DEF,
	parameter int EXP_TABLE_DEPTH = elu_pkg::EXP_DEPTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  en,
	input  wire logic signed [elu_pkg::DATA_WIDTH-1:0] x,
	input  wire logic        [elu_pkg::ALPHA_W-1:0]    alpha,
	output logic signed      [elu_pkg::DATA_WIDTH-1:0] fwd_res
);

	localparam int DW = elu_pkg::DATA_WIDTH;
	localparam int EW = elu_pkg::EXP_W;
	localparam int XW = DW + 1;
	localparam int SH_F = FRAC_BITS + 3;
	localparam int CW = (XW > SH_F + 1) ? XW : SH_F + 1;
	localparam int PW = XW + $clog2(EXP_TABLE_DEPTH + 1);
	localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
	localparam int LW = EW + SH_F;
	localparam int MW = elu_pkg::ALPHA_W + EW;
	localparam int RS = 38 - FRAC_BITS;
	localparam logic [CW-1:0] DEN = CW'(1) << SH_F;
	localparam logic [MW:0] HALF = (MW + 1)'(1) << (RS - 1);
	localparam logic [MW:0] LIM = (MW + 1)'(1) << (DW - 1);
	localparam logic [DW-1:0] MIN_VAL = DW'(1) << (DW - 1);

	// stage 1: magnitude, table position
	logic signed [XW-1:0] x_ext;
	logic signed [XW-1:0] x_neg;
	logic [XW-1:0]        m;
	logic [PW-1:0]        pos;
	logic [PW-1:0]        pos_int;
	logic                 over;
	logic                 at_end;

	logic [IDX_W-1:0] idx_s1;
	logic [SH_F-1:0]  f_s1;
	logic             zero_s1;
	logic             end_s1;

	assign x_ext   = {x[DW-1], x};
	assign x_neg   = -x_ext;
	assign m       = x_neg;
	assign pos     = PW'(m) * PW'(EXP_TABLE_DEPTH);
	assign pos_int = pos >> SH_F;
	assign over    = CW'(m) > DEN;
	assign at_end  = CW'(m) == DEN;

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1  <= at_end ? IDX_W'(EXP_TABLE_DEPTH - 1) : pos_int[IDX_W-1:0];
			f_s1    <= pos[SH_F-1:0];
			zero_s1 <= over;
			end_s1  <= at_end;
		end
	end

	// stage 2: table read, segment slope
	logic [EW-1:0] ent_lo;
	logic [EW-1:0] ent_hi;
	logic [EW-1:0] t_s2;
	logic [EW-1:0] diff_s2;
	logic [SH_F-1:0] f_s2;

	elu_exp_rom #(
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH),
		.IDX_W(IDX_W)
	) u_rom (
		.idx(idx_s1),
		.ent_lo(ent_lo),
		.ent_hi(ent_hi)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s1) begin
				t_s2    <= '0;
				diff_s2 <= '0;
			end else if (end_s1) begin
				t_s2    <= ent_hi;
				diff_s2 <= '0;
			end else begin
				t_s2    <= ent_lo;
				diff_s2 <= ent_lo - ent_hi;
			end
			f_s2 <= f_s1;
		end
	end

	// stage 3: interpolation product
	logic [LW-1:0] prod_s3;
	logic [EW-1:0] t_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= LW'(diff_s2) * LW'(f_s2);
			t_s3    <= t_s2;
		end
	end

	// stage 4: 1 - exp(x) in Q30
	logic [EW:0]   ome_sum;
	logic [EW-1:0] ome_s4;

	assign ome_sum = (EW + 1)'(elu_pkg::EXP_ONE) - (EW + 1)'(t_s3)
		+ (EW + 1)'(prod_s3 >> SH_F);

	always_ff @(posedge clk) begin
		if (en) begin
			ome_s4 <= ome_sum[EW-1:0];
		end
	end

	// stage 5: alpha scaling
	logic [MW-1:0] mag_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5 <= MW'(alpha) * MW'(ome_s4);
		end
	end

	// round half away from zero, negate, saturate
	logic [MW:0] rnd;
	logic [MW:0] q;
	logic [MW:0] q_neg;

	assign rnd   = (MW + 1)'(mag_s5) + HALF;
	assign q     = rnd >> RS;
	assign q_neg = -q;

	always_comb begin
		if (q > LIM) begin
			fwd_res = MIN_VAL;
		end else begin
			fwd_res = q_neg[DW-1:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/elu_grad.sv */
`default_nettype none

// ELU gradient: dy * (alpha + y) for y <= 0, dy for y > 0; five register stages
module elu_grad #(
	parameter int FRAC_BITS = elu_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  en,
	input  wire logic signed [elu_pkg::DATA_WIDTH-1:0] y,
	input  wire logic signed [elu_pkg::DATA_WIDTH-1:0] dy,
	input  wire logic        [elu_pkg::ALPHA_W-1:0]    alpha,
	output logic signed      [elu_pkg::DATA_WIDTH-1:0] grad_s5
);

	localparam int DW = elu_pkg::DATA_WIDTH;
	localparam int AS_W = elu_pkg::ALPHA_W + FRAC_BITS + 1;
	localparam int A_W = AS_W - 8;
	localparam int FW = ((A_W + 1 > DW) ? A_W + 1 : DW) + 1;
	localparam int PW = DW + FW;
	localparam logic [PW:0] HALF = (PW + 1)'(1) << (FRAC_BITS - 1);
	localparam logic [PW:0] LIM_NEG = (PW + 1)'(1) << (DW - 1);
	localparam logic [PW:0] LIM_POS = LIM_NEG - (PW + 1)'(1);
	localparam logic [DW-1:0] MIN_VAL = DW'(1) << (DW - 1);
	localparam logic [DW-1:0] MAX_VAL = ~MIN_VAL;

	// stage 1: alpha in data format, slope factor
	logic [AS_W-1:0] a_sum;
	logic [A_W-1:0]  a_val;

	logic signed [FW-1:0] factor_s1;
	logic signed [DW-1:0] dy_s1;
	logic                 ypos_s1;

	assign a_sum = (AS_W'(alpha) << FRAC_BITS) + AS_W'(128);
	assign a_val = a_sum[AS_W-1:8];

	always_ff @(posedge clk) begin
		if (en) begin
			factor_s1 <= FW'($signed({1'b0, a_val})) + FW'(y);
			dy_s1     <= dy;
			ypos_s1   <= y > 0;
		end
	end

	// stage 2: product
	logic signed [PW-1:0] prod_s2;
	logic signed [DW-1:0] dy_s2;
	logic                 ypos_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PW'(dy_s1) * PW'(factor_s1);
			dy_s2   <= dy_s1;
			ypos_s2 <= ypos_s1;
		end
	end

	// stage 3: sign and magnitude
	logic [PW-1:0]        mag_s3;
	logic                 neg_s3;
	logic signed [DW-1:0] dy_s3;
	logic                 ypos_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3  <= prod_s2[PW-1] ? PW'(-prod_s2) : PW'(prod_s2);
			neg_s3  <= prod_s2[PW-1];
			dy_s3   <= dy_s2;
			ypos_s3 <= ypos_s2;
		end
	end

	// stage 4: round half away from zero
	logic [PW:0]          q_s4;
	logic                 neg_s4;
	logic signed [DW-1:0] dy_s4;
	logic                 ypos_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			q_s4    <= ((PW + 1)'(mag_s3) + HALF) >> FRAC_BITS;
			neg_s4  <= neg_s3;
			dy_s4   <= dy_s3;
			ypos_s4 <= ypos_s3;
		end
	end

	// stage 5: restore sign, saturate
	logic [PW:0] q_neg;

	assign q_neg = -q_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			if (ypos_s4) begin
				grad_s5 <= dy_s4;
			end else if (neg_s4) begin
				grad_s5 <= (q_s4 > LIM_NEG) ? MIN_VAL : q_neg[DW-1:0];
			end else begin
				grad_s5 <= (q_s4 > LIM_POS) ? MAX_VAL : q_s4[DW-1:0];
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/elu_activation_and_gradient.sv */
// Elementwise ELU and ELU gradient on signed fixed-point data (Q8.8 by default).
//
// Request channel req_*: one element per beat, req_valid/req_stall. func selects
// the forward activation (0) or the input gradient (1); last_in rides along.
// Response channel rsp_*: exactly one result beat per request beat, in order,
// with last_out equal to the request's last_in.
// Config: cfg_we writes cfg_wdata into alpha (unsigned Q4.8) at the clock edge.
// Write it only while no element is in flight.
//
// Throughput: one element per cycle while rsp_stall does not hold the
// pipeline; the path is a six-stage pipeline (table lookup, interpolation
// multiply, alpha multiply, round/saturate), no stage holding more than one
// multiplier per path.
// Reset (arst_n low) empties the pipeline and sets alpha to 1.0.
// Stall: while rsp_valid is high and rsp_stall is high the whole pipeline
// freezes and req_stall is raised; nothing is dropped or repeated.
`default_nettype none

`include "assert_macros.svh"

module elu_activation_and_gradient #(
	parameter int FRAC_BITS = elu_pkg::FRAC_BITS_DEF,
	parameter int EXP_TABLE_DEPTH = elu_pkg::EXP_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire elu_pkg::req_beat_t             req_beat,
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output elu_pkg::rsp_beat_t                  rsp_beat,
	input  wire logic                           cfg_we,
	input  wire logic [elu_pkg::ALPHA_W-1:0]    cfg_wdata
);

	localparam int DW = elu_pkg::DATA_WIDTH;

	typedef struct packed {
		logic                 func;
		logic                 last;
		logic                 pos;
		logic signed [DW-1:0] x;
	} ctl_t;

	logic pipe_en;
	logic [elu_pkg::ALPHA_W-1:0] alpha_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	elu_pkg::rsp_beat_t rsp_s6;

	logic signed [DW-1:0] fwd_res;
	logic signed [DW-1:0] grad_s5;

	// global advance: the output register is free or being drained
	assign pipe_en   = !vld_s6 || !rsp_stall;
	assign req_stall = !pipe_en;

	// alpha register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= elu_pkg::ALPHA_RST;
		end else if (cfg_we) begin
			alpha_q <= cfg_wdata;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (pipe_en) begin
			vld_s1 <= req_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// side data traveling with each beat
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ctl_s1 <= '{func: req_beat.func, last: req_beat.last_in,
				pos: req_beat.operand > 0, x: req_beat.operand};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	elu_fwd #(
		.FRAC_BITS(FRAC_BITS),
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_fwd (
		.clk(clk),
		.en(pipe_en),
		.x(req_beat.operand),
		.alpha(alpha_q),
		.fwd_res(fwd_res)
	);

	elu_grad #(
		.FRAC_BITS(FRAC_BITS)
	) u_grad (
		.clk(clk),
		.en(pipe_en),
		.y(req_beat.operand),
		.dy(req_beat.upstream_grad),
		.alpha(alpha_q),
		.grad_s5(grad_s5)
	);

	// output register: pick gradient, pass-through or forward value
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			if (ctl_s5.func == elu_pkg::FN_GRAD) begin
				rsp_s6.result <= grad_s5;
			end else if (ctl_s5.pos) begin
				rsp_s6.result <= ctl_s5.x;
			end else begin
				rsp_s6.result <= fwd_res;
			end
			rsp_s6.last_out <= ctl_s5.last;
		end
	end

	assign rsp_valid = vld_s6;
	assign rsp_beat  = rsp_s6;

	// forward output on the non-positive side is never positive
	`ELU_ASSERT_NEXT(a_fwd_nonpos, vld_s5 && pipe_en && ctl_s5.func == elu_pkg::FN_FWD &&
		!ctl_s5.pos, rsp_s6.result <= 0, "forward ELU of non-positive input came out positive")
	// a beat in the last stage reaches the output when the pipe advances
	`ELU_ASSERT_NEXT(a_advance, vld_s5 && pipe_en, rsp_valid,
		"beat lost between last stage and output register")
	// a held pipe keeps its occupancy
	`ELU_ASSERT_NEXT(a_freeze, !pipe_en,
		$stable({vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6}),
		"pipeline valid bits moved while stalled")

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none

module tb_top;

	typedef longint unsigned u64_t;

	localparam int DW        = elu_pkg::DATA_WIDTH;
	localparam int FRAC      = elu_pkg::FRAC_BITS_DEF;
	localparam int DEPTH     = elu_pkg::EXP_DEPTH_DEF;
	localparam u64_t Q30     = u64_t'(elu_pkg::EXP_ONE);
	localparam u64_t EXP_DEN = u64_t'(8) << FRAC;
	localparam int LIMIT     = 400000;
	localparam int DRAIN     = 12;
	localparam int SQUEEZE   = 80;
	localparam int N_DIR     = 22;

	// One row of the directed table; want is used only when typed is set
	typedef struct packed {
		logic                 func;
		logic signed [DW-1:0] opnd;
		logic signed [DW-1:0] dy;
		logic                 last;
		logic                 typed;
		logic signed [DW-1:0] want;
	} dir_vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	elu_pkg::req_beat_t req_beat = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	elu_pkg::rsp_beat_t rsp_beat;
	logic cfg_we = 1'b0;
	logic [elu_pkg::ALPHA_W-1:0] cfg_wdata = '0;

	// Idling controls, changed by the stimulus between phases
	logic tx_idle = 1'b1;
	logic rx_idle = 1'b1;
	logic squeeze_req = 1'b0;
	bit squeeze_done = 1'b0;

	u64_t exp_lut [0:DEPTH];
	logic [elu_pkg::ALPHA_W-1:0] alpha_q;
	elu_pkg::rsp_beat_t elu_pending [$];
	dir_vec_t dir_tab [N_DIR];
	int err_count = 0;
	int rsp_count = 0;
	int unsigned cycles = 0;

	elu_activation_and_gradient uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_beat(req_beat),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_beat(rsp_beat),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("elu_activation_and_gradient: mismatch");
			$finish;
		end
	end

	task automatic report_error(string msg);
		if (err_count < 100)
			$display("%s", msg);
		err_count++;
	endtask

	// round(p / 2^s), half away from zero
	function automatic longint round_shr(longint p, int s);
		u64_t mag;
		u64_t q;
		mag = (p < 0) ? u64_t'(-p) : u64_t'(p);
		q = (mag + (u64_t'(1) << (s - 1))) >> s;
		return (p < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [DW-1:0] clamp_word(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) << (DW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return DW'(hi);
		if (v < lo)
			return DW'(lo);
		return DW'(v);
	endfunction

	// Expected result beat for one request beat under the given alpha
	function automatic elu_pkg::rsp_beat_t elu_expected(elu_pkg::req_beat_t b,
		logic [elu_pkg::ALPHA_W-1:0] alpha);
		elu_pkg::rsp_beat_t o;
		longint x;
		longint dy;
		longint a;
		longint r;
		u64_t m;
		u64_t p;
		u64_t idx;
		u64_t frac;
		u64_t e;
		u64_t mag;
		x = longint'(b.operand);
		dy = longint'(b.upstream_grad);
		if (b.func == elu_pkg::FN_GRAD) begin
			if (x > 0) begin
				r = dy;
			end else begin
				a = longint'(((u64_t'(alpha) << FRAC) + 128) >> 8);
				r = round_shr(dy * (a + x), FRAC);
			end
		end else if (x > 0) begin
			r = x;
		end else begin
			m = u64_t'(-x);
			// exp is zero below -8, last entry at exactly -8
			if (m > EXP_DEN) begin
				e = 0;
			end else begin
				p = m * u64_t'(DEPTH);
				idx = p / EXP_DEN;
				frac = p % EXP_DEN;
				if (idx >= u64_t'(DEPTH))
					e = exp_lut[DEPTH];
				else
					e = exp_lut[idx] - ((exp_lut[idx] - exp_lut[idx + 1]) * frac) / EXP_DEN;
			end
			mag = u64_t'(alpha) * (Q30 - e);
			r = round_shr(-longint'(mag), 38 - FRAC);
		end
		o.result = clamp_word(r);
		o.last_out = b.last_in;
		return o;
	endfunction

	function automatic int pick_gap(logic idle_on);
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Operand mix: full range, interpolation region, segment edges, both sides
	function automatic logic signed [DW-1:0] pick_operand();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			v = int'($urandom);
		end else if (r < 65) begin
			v = -int'($urandom_range(0, 2048));
		end else if (r < 77) begin
			case ($urandom_range(0, 5))
				0: v = -2049;
				1: v = -2048;
				2: v = -2047;
				3: v = 0;
				4: v = 1;
				default: v = -1;
			endcase
		end else if (r < 90) begin
			v = $urandom_range(1, 1024);
		end else begin
			v = -int'($urandom_range(2049, 32768));
		end
		return DW'(v);
	endfunction

	function automatic elu_pkg::req_beat_t random_beat();
		elu_pkg::req_beat_t b;
		b.func = ($urandom_range(0, 1) == 1) ? elu_pkg::FN_GRAD : elu_pkg::FN_FWD;
		b.operand = pick_operand();
		// gradient factor near zero: y close to -alpha
		if (b.func == elu_pkg::FN_GRAD && $urandom_range(0, 99) < 25)
			b.operand = DW'(-int'(alpha_q) + int'($urandom_range(0, 8)) - 4);
		if ($urandom_range(0, 1) == 1)
			b.upstream_grad = DW'($urandom);
		else
			b.upstream_grad = DW'(int'($urandom_range(0, 1200)) - 600);
		b.last_in = ($urandom_range(0, 7) == 0);
		return b;
	endfunction

	// Offer one beat, hold it until accepted, then record what it should produce
	task automatic send_beat(elu_pkg::req_beat_t b, logic typed,
		logic signed [DW-1:0] want);
		elu_pkg::rsp_beat_t e;
		int gap;
		req_valid <= 1'b1;
		req_beat <= b;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (typed) begin
			e.result = want;
			e.last_out = b.last_in;
		end else begin
			e = elu_expected(b, alpha_q);
		end
		elu_pending.push_back(e);
		gap = pick_gap(tx_idle);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Alpha changes only once the pipeline has emptied
	task automatic write_alpha(logic [elu_pkg::ALPHA_W-1:0] v);
		req_valid <= 1'b0;
		while (elu_pending.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		alpha_q = v;
	endtask

	// Receiver stall pattern, with one long hold-off to back the pipeline up
	initial begin : rsp_side
		int r;
		int len;
		logic st;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (squeeze_req && !squeeze_done && rsp_valid) begin
				st = 1'b1;
				len = SQUEEZE;
				squeeze_done = 1'b1;
			end else if (!rx_idle) begin
				st = 1'b0;
				len = 1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					st = 1'b0;
					len = $urandom_range(1, 4);
				end else if (r < 95) begin
					st = 1'b1;
					len = $urandom_range(1, 3);
				end else begin
					st = 1'b1;
					len = $urandom_range(15, 40);
				end
			end
			rsp_stall <= st;
			repeat (len) @(posedge clk);
		end
	end

	// Result beats against the oldest expectation
	always @(posedge clk) begin : rsp_check
		elu_pkg::rsp_beat_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (elu_pending.size() == 0) begin
				report_error($sformatf("beat %0d: unexpected result %0d last %b",
					rsp_count, rsp_beat.result, rsp_beat.last_out));
			end else begin
				want = elu_pending.pop_front();
				if (rsp_beat.result !== want.result || rsp_beat.last_out !== want.last_out)
					report_error($sformatf("beat %0d: result %0d last %b, want %0d last %b",
						rsp_count, rsp_beat.result, rsp_beat.last_out,
						want.result, want.last_out));
			end
			rsp_count <= rsp_count + 1;
		end
	end

	initial begin : stimulus
		u64_t h;
		u64_t term;
		u64_t ratio;
		elu_pkg::req_beat_t b;
		logic [elu_pkg::ALPHA_W-1:0] av;
		int k;
		int ph;

		// exp(-8i/DEPTH) table: Taylor step ratio, then repeated rounded products
		h = (u64_t'(8) * Q30) / u64_t'(DEPTH);
		term = Q30;
		ratio = Q30;
		for (k = 1; k <= 24; k++) begin
			term = (term * h) / (u64_t'(k) * Q30);
			if (k % 2 == 1)
				ratio = ratio - term;
			else
				ratio = ratio + term;
		end
		exp_lut[0] = Q30;
		for (k = 1; k <= DEPTH; k++)
			exp_lut[k] = (exp_lut[k - 1] * ratio + (Q30 >> 1)) >> 30;

		// Directed rows at the reset alpha of 1.0
		dir_tab = '{
			'{elu_pkg::FN_FWD,  16'sd32767,  16'sd0,      1'b0, 1'b1, 16'sd32767},
			'{elu_pkg::FN_FWD,  16'sd1,      16'sd0,      1'b0, 1'b1, 16'sd1},
			'{elu_pkg::FN_FWD,  16'sd0,      16'sd0,      1'b0, 1'b1, 16'sd0},
			'{elu_pkg::FN_FWD,  -16'sd1,     16'sd0,      1'b0, 1'b0, 16'sd0},
			'{elu_pkg::FN_FWD,  -16'sd128,   16'sd0,      1'b0, 1'b0, 16'sd0},
			'{elu_pkg::FN_FWD,  -16'sd2047,  16'sd0,      1'b0, 1'b0, 16'sd0},
			'{elu_pkg::FN_FWD,  -16'sd2048,  16'sd0,      1'b0, 1'b0, 16'sd0},
			'{elu_pkg::FN_FWD,  -16'sd2049,  16'sd0,      1'b0, 1'b1, -16'sd256},
			'{elu_pkg::FN_FWD,  16'sh8000,   16'sd0,      1'b1, 1'b1, -16'sd256},
			'{elu_pkg::FN_FWD,  -16'sd512,   16'sh8000,   1'b0, 1'b0, 16'sd0},
			'{elu_pkg::FN_GRAD, 16'sd32767,  16'sh8000,   1'b0, 1'b1, 16'sh8000},
			'{elu_pkg::FN_GRAD, 16'sd1,      16'sd32767,  1'b0, 1'b1, 16'sd32767},
			'{elu_pkg::FN_GRAD, 16'sd0,      16'sd256,    1'b0, 1'b1, 16'sd256},
			'{elu_pkg::FN_GRAD, 16'sd0,      16'sh8000,   1'b0, 1'b1, 16'sh8000},
			'{elu_pkg::FN_GRAD, 16'sh8000,   16'sh8000,   1'b0, 1'b1, 16'sd32767},
			'{elu_pkg::FN_GRAD, 16'sh8000,   16'sd32767,  1'b1, 1'b1, 16'sh8000},
			'{elu_pkg::FN_GRAD, -16'sd128,   16'sd1,      1'b0, 1'b0, 16'sd0},
			'{elu_pkg::FN_GRAD, -16'sd128,   -16'sd1,     1'b0, 1'b0, 16'sd0},
			'{elu_pkg::FN_GRAD, -16'sd256,   16'sd12345,  1'b0, 1'b1, 16'sd0},
			'{elu_pkg::FN_GRAD, -16'sd100,   16'sd0,      1'b1, 1'b1, 16'sd0},
			'{elu_pkg::FN_FWD,  -16'sd1024,  16'sd0,      1'b1, 1'b0, 16'sd0},
			'{elu_pkg::FN_GRAD, -16'sd300,   -16'sd1000,  1'b0, 1'b0, 16'sd0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		alpha_q = elu_pkg::ALPHA_RST;

		for (k = 0; k < N_DIR; k++) begin
			b.func = dir_tab[k].func;
			b.operand = dir_tab[k].opnd;
			b.upstream_grad = dir_tab[k].dy;
			b.last_in = dir_tab[k].last;
			send_beat(b, dir_tab[k].typed, dir_tab[k].want);
		end

		// Random phases, one alpha each; phase 2 runs without idling,
		// phase 4 keeps the sender busy while the receiver holds off
		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: av = '0;
				1: av = elu_pkg::ALPHA_W'(2560);
				5: av = elu_pkg::ALPHA_W'(1);
				7: av = elu_pkg::ALPHA_W'(2559);
				default: av = elu_pkg::ALPHA_W'($urandom_range(0, 2560));
			endcase
			tx_idle <= (ph != 2 && ph != 4);
			rx_idle <= (ph != 2);
			squeeze_req <= (ph == 4);
			write_alpha(av);
			for (k = 0; k < 75; k++)
				send_beat(random_beat(), 1'b0, '0);
		end

		req_valid <= 1'b0;
		while (elu_pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (err_count == 0)
			$display("elu_activation_and_gradient: match");
		else
			$display("elu_activation_and_gradient: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
